@@ rtl/core/unison_wavetable_oscillator_assert.svh @@
// Assertion macros for the unison wavetable oscillator.
// Used by the top level only.
`ifndef UNISON_WAVETABLE_OSCILLATOR_ASSERT_SVH
`define UNISON_WAVETABLE_OSCILLATOR_ASSERT_SVH
// implication checked every clock, quiet during reset
`define UWO_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define UWO_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

@@ rtl/core/uwo_pkg.sv @@
// Package for the unison wavetable oscillator: constants, types, sine table.
// No dependencies.
`timescale 1ns / 1ps
package uwo_pkg;
   localparam int TABLE_SIZE_DEF  = 1024;
   localparam int MAX_VOICES_DEF  = 15;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   localparam logic [2:0] WAVE_SINE   = 3'd0;
   localparam logic [2:0] WAVE_SQUARE = 3'd1;
   localparam logic [2:0] WAVE_TRI    = 3'd2;
   localparam logic [2:0] WAVE_SAW    = 3'd3;
   localparam logic [2:0] WAVE_NOISE  = 3'd4;

   localparam logic [2:0] REG_WAVEFORM = 3'd0;
   localparam logic [2:0] REG_OFFSET   = 3'd1;
   localparam logic [2:0] REG_DUTY     = 3'd2;
   localparam logic [2:0] REG_VOICES   = 3'd3;
   localparam logic [2:0] REG_DETUNE   = 3'd4;
   localparam logic [2:0] REG_PPHZ     = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE, ST_STEP, ST_WAVE, ST_ACCUM, ST_DIV, ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic start;    // latch input, clear sum
      logic step;     // multiply for current voice
      logic wave;     // phase update and lookup
      logic accum;    // add to sum, next voice
      logic div_init;
      logic div_step;
      logic noise;    // step the lfsr
      logic zero;     // undefined waveform
      logic present;  // load output
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_voice;
      logic div_done;
   } status_type;

   // pi/2 in Q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [255:0][14:0] sine_table_type;

   // round(16384*sin(pi/2*i/256)), Q30 integer Taylor series up to x^15;
   // evaluated once at elaboration into a constant table
   function automatic sine_table_type sine_table();
      sine_table_type tbl;
      logic [63:0] x, x2, t;
      longint sum;
      for (int i = 0; i < 256; i++) begin
         x = (HALF_PI_Q30 * 64'(i)) >> 8;
         x2 = (x * x) >> 30;
         t = x;
         sum = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) sum = sum - longint'(t);
            else sum = sum + longint'(t);
         end
         if (sum < 0) sum = 0;
         tbl[i] = 15'(((64'(sum) * 64'd16384) + (64'd1 << 29)) >> 30);
      end
      return tbl;
   endfunction
endpackage

@@ rtl/core/uwo_if.sv @@
// Valid/ready channel interfaces for the oscillator.
// Depends on nothing.
`timescale 1ns / 1ps
interface uwo_req_if;
   logic        valid;
   logic        ready;
   logic [18:0] frequency;
   modport source (output valid, output frequency, input ready);
   modport sink   (input valid, input frequency, output ready);
endinterface

interface uwo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface uwo_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/unison_wavetable_oscillator.sv @@
// Channel   | dir | transfer
// req       | in  | frequency, 19 bits, valid/ready
// rsp       | out | sample, signed 16 bits, valid/ready
// csr       | in  | index 3 bits, data 32 bits, valid/ready
// Per item: step, wave and accumulate states per voice, then the serial
// divider; noise and undefined codes go straight to output. A request is taken
// only after the last is presented. Synchronous reset clears phases, the LFSR
// and config registers. A waiting result blocks only the next presentation.
`timescale 1ns / 1ps
`include "unison_wavetable_oscillator_assert.svh"
module unison_wavetable_oscillator #(
   parameter int TABLE_SIZE  = uwo_pkg::TABLE_SIZE_DEF,
   parameter int MAX_VOICES  = uwo_pkg::MAX_VOICES_DEF,
   parameter int SAMPLE_BITS = uwo_pkg::SAMPLE_BITS_DEF
) (
   input logic clock,
   input logic reset,
   uwo_req_if.sink   req,
   uwo_rsp_if.source rsp,
   uwo_csr_if.sink   csr
);
   logic [2:0]  waveform_ff;
   logic [9:0]  offset_ff;
   logic signed [15:0] duty_ff;
   logic [3:0]  voices_ff;
   logic [19:0] detune_ff;
   logic [31:0] pphz_ff;
   uwo_pkg::cmd_type cmd;
   uwo_pkg::status_type status;

   assign csr.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff <= uwo_pkg::WAVE_SINE;
         offset_ff <= '0;
         duty_ff <= '0;
         voices_ff <= 4'd1;
         detune_ff <= '0;
         pphz_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            uwo_pkg::REG_WAVEFORM: waveform_ff <= csr.data[2:0];
            uwo_pkg::REG_OFFSET:   offset_ff <= csr.data[9:0];
            uwo_pkg::REG_DUTY:     duty_ff <= csr.data[15:0];
            uwo_pkg::REG_VOICES:   voices_ff <= csr.data[3:0];
            uwo_pkg::REG_DETUNE:   detune_ff <= csr.data[19:0];
            uwo_pkg::REG_PPHZ:     pphz_ff <= csr.data;
            default: ;
         endcase
      end
   end

   uwo_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .waveform(waveform_ff), .status, .cmd
   );

   uwo_datapath #(
      .TABLE_SIZE(TABLE_SIZE), .MAX_VOICES(MAX_VOICES), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .status,
      .frequency(req.frequency), .waveform(waveform_ff),
      .phase_offset(offset_ff), .duty_threshold(duty_ff),
      .voice_count(voices_ff), .detune(detune_ff), .phase_per_hz(pphz_ff),
      .sample(rsp.sample)
   );

   `UWO_ASSERT_NEXT(a_present_valid, clock, reset, cmd.present, rsp.valid)
   `UWO_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1,
      $onehot0({cmd.step, cmd.wave, cmd.accum, cmd.div_step, cmd.present}))
   `UWO_ASSERT_IMP(a_no_overwrite, clock, reset, rsp.valid && !rsp.ready, !cmd.present)
endmodule

@@ rtl/core/uwo_ctrl.sv @@
// Sequencer for the oscillator: one voice per pass, then divide and present.
// Depends on uwo_pkg.
`timescale 1ns / 1ps
module uwo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [2:0]          waveform,
   input  uwo_pkg::status_type status,
   output uwo_pkg::cmd_type    cmd
);
   uwo_pkg::state_type state_ff, state_in;
   logic valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uwo_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff & ~rsp_ready;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         uwo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (waveform == uwo_pkg::WAVE_NOISE) begin
                  cmd.noise = 1'b1;
                  state_in = uwo_pkg::ST_OUT;
               end else if (waveform > uwo_pkg::WAVE_NOISE) begin
                  cmd.zero = 1'b1;
                  state_in = uwo_pkg::ST_OUT;
               end else begin
                  state_in = uwo_pkg::ST_STEP;
               end
            end
         end
         uwo_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            state_in = uwo_pkg::ST_WAVE;
         end
         uwo_pkg::ST_WAVE: begin
            cmd.wave = 1'b1;
            state_in = uwo_pkg::ST_ACCUM;
         end
         uwo_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.last_voice) begin
               cmd.div_init = 1'b1;
               state_in = uwo_pkg::ST_DIV;
            end else begin
               state_in = uwo_pkg::ST_STEP;
            end
         end
         uwo_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = uwo_pkg::ST_OUT;
         end
         uwo_pkg::ST_OUT: begin
            // wait until the output register is free
            if (!valid_ff || rsp_ready) begin
               cmd.present = 1'b1;
               valid_in = 1'b1;
               state_in = uwo_pkg::ST_IDLE;
            end
         end
         default: state_in = uwo_pkg::ST_IDLE;
      endcase
   end
endmodule

@@ rtl/core/uwo_datapath.sv @@
// Oscillator datapath: phase registers, step multiplier, wave lookup,
// sum, restoring divider, LFSR and output register. Depends on uwo_pkg.
`timescale 1ns / 1ps
module uwo_datapath #(
   parameter int TABLE_SIZE  = uwo_pkg::TABLE_SIZE_DEF,
   parameter int MAX_VOICES  = uwo_pkg::MAX_VOICES_DEF,
   parameter int SAMPLE_BITS = uwo_pkg::SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  uwo_pkg::cmd_type    cmd,
   output uwo_pkg::status_type status,
   input  logic [18:0]         frequency,
   input  logic [2:0]          waveform,
   input  logic [9:0]          phase_offset,
   input  logic signed [15:0]  duty_threshold,
   input  logic [3:0]          voice_count,
   input  logic [19:0]         detune,
   input  logic [31:0]         phase_per_hz,
   output logic signed [15:0]  sample
);
   localparam int TB = $clog2(TABLE_SIZE);
   localparam int VB = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int SB = 16 + 4 + 1;
   localparam logic [15:0] SMASK = (SAMPLE_BITS < 16) ?
                                   16'hFFFF << (16 - SAMPLE_BITS) : 16'hFFFF;
   localparam uwo_pkg::sine_table_type SINE_TABLE = uwo_pkg::sine_table();

   logic [31:0] phase_ff [MAX_VOICES];
   logic [18:0] freq_ff;
   logic [VB-1:0] voice_ff;
   logic [3:0] count_ff;
   logic [51:0] prod_ff;
   logic neg_ff;
   logic signed [16:0] wave_ff;
   logic signed [SB-1:0] sum_ff;
   logic [15:0] lfsr_ff, lfsr_in;
   logic [19:0] rem_ff, quo_ff;
   logic [4:0] dcnt_ff;
   logic dneg_ff;
   logic signed [15:0] sample_ff;

   // effective count, clamped
   logic [3:0] cnt_eff;
   always_comb begin
      cnt_eff = (voice_count == 4'd0) ? 4'd1 : voice_count;
      if ({1'b0, cnt_eff} > 5'(MAX_VOICES)) cnt_eff = 4'(MAX_VOICES);
   end

   // effective frequency of current voice
   logic signed [21:0] feff;
   logic [20:0] fmag;
   always_comb begin
      if (voice_ff == '0) feff = 22'(freq_ff);
      else if (voice_ff[0]) feff = 22'(freq_ff) - 22'(detune);
      else feff = 22'(freq_ff) + 22'(detune);
      fmag = feff[21] ? 21'(-feff) : 21'(feff);
   end

   // step and lookup phase
   logic [31:0] inc, stepv, newph, lp;
   logic [TB-1:0] k;
   always_comb begin
      inc = prod_ff[TB+31:TB];
      stepv = neg_ff ? 32'(0 - inc) : inc;
      newph = phase_ff[voice_ff] + stepv;
      k = newph[31:32-TB] + TB'(phase_offset);
      lp = {k, {(32-TB){1'b0}}};
   end

   // waveform value
   logic [7:0] addr;
   logic signed [15:0] hs;
   logic [14:0] rv;
   logic signed [17:0] u, tri_v;
   logic signed [16:0] wv;
   always_comb begin
      addr = lp[29:22];
      rv = SINE_TABLE[lp[30] ? 8'(9'd256 - {1'b0, addr}) : addr];
      if (lp[30] && addr == 8'd0) rv = 15'd16384;
      hs = lp[31] ? -$signed({1'b0, rv}) : $signed({1'b0, rv});
      u = $signed({2'b00, lp[31:16]});
      if (u < 18'sd16384) tri_v = u <<< 1;
      else if (u < 18'sd49152) tri_v = 18'sd65536 - (u <<< 1);
      else tri_v = (u - 18'sd65536) <<< 1;
      case (waveform)
         uwo_pkg::WAVE_SINE: wv = 17'(hs);
         uwo_pkg::WAVE_SQUARE:
            wv = ($signed({hs, 1'b0}) > 17'(duty_threshold)) ? 17'sd32767 : -17'sd32768;
         uwo_pkg::WAVE_TRI: wv = (tri_v > 18'sd32767) ? 17'sd32767 : 17'(tri_v);
         default: wv = 17'($signed(lp[31:16]));
      endcase
   end

   always_comb begin
      lfsr_in = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? uwo_pkg::LFSR_TAPS : 16'h0);
   end

   // restoring division of |sum| by count
   logic [20:0] trial;
   assign trial = {rem_ff, quo_ff[19]} - {17'd0, count_ff};

   assign status.last_voice = ({1'b0, voice_ff} + 5'd1) >= {1'b0, count_ff};
   assign status.div_done = (dcnt_ff == 5'd19);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) phase_ff[i] <= '0;
         lfsr_ff <= uwo_pkg::LFSR_SEED;
      end else begin
         if (cmd.wave) phase_ff[voice_ff] <= newph;
         if (cmd.noise) lfsr_ff <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         freq_ff <= frequency;
         voice_ff <= '0;
         count_ff <= cnt_eff;
         sum_ff <= '0;
         // noise and undefined codes park their value in the quotient
         if (cmd.noise) begin
            quo_ff <= {4'd0, lfsr_in};
            dneg_ff <= 1'b0;
         end
         if (cmd.zero) begin
            quo_ff <= '0;
            dneg_ff <= 1'b0;
         end
      end
      if (cmd.step) begin
         prod_ff <= 52'(fmag) * 52'(phase_per_hz);
         neg_ff <= feff[21];
      end
      if (cmd.wave) wave_ff <= wv;
      if (cmd.accum) begin
         sum_ff <= sum_ff + SB'(wave_ff);
         voice_ff <= VB'(voice_ff + 1'b1);
      end
      if (cmd.div_init) begin
         dneg_ff <= sum_ff[SB-1] ^ wave_ff[16] ? (sum_ff + SB'(wave_ff)) < 0
                                              : sum_ff[SB-1];
         quo_ff <= 20'((sum_ff + SB'(wave_ff)) < 0 ? -(sum_ff + SB'(wave_ff))
                                                   : (sum_ff + SB'(wave_ff)));
         rem_ff <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!trial[20]) begin
            rem_ff <= trial[19:0];
            quo_ff <= {quo_ff[18:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[18:0], quo_ff[19]};
            quo_ff <= {quo_ff[18:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (cmd.present) begin
         sample_ff <= (dneg_ff ? 16'(-quo_ff) : 16'(quo_ff)) & SMASK;
      end
   end

   assign sample = sample_ff;
endmodule

@@ tb/uwo_tb_if.sv @@
// Testbench-side note: channel interfaces come from the RTL file uwo_if.sv.
// This file holds small shared testbench types; depends on nothing.
`timescale 1ns / 1ps
package uwo_tb_pkg;
   typedef struct {
      logic [2:0]  index;
      logic [31:0] data;
   } csr_write_type;
endpackage

@@ tb/tb_top.sv @@
// Self-checking testbench for unison_wavetable_oscillator: drives sample ticks,
// predicts each output sample with a behavioral NCO, compares at the rsp port.
// Depends on uwo_pkg, uwo_if.sv and uwo_tb_pkg.
`timescale 1ns / 1ps
module tb_top;
   logic clock;
   logic reset;
   uwo_req_if req ();
   uwo_rsp_if rsp ();
   uwo_csr_if csr ();

   unison_wavetable_oscillator DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   // predictor state
   logic [2:0]   p_wave;
   logic [9:0]   p_offset;
   logic signed [15:0] p_duty;
   logic [3:0]   p_voices;
   logic [19:0]  p_detune;
   logic [31:0]  p_pphz;
   logic [31:0]  p_phase [uwo_pkg::MAX_VOICES_DEF];
   logic [15:0]  p_lfsr;
   int           quarter_sine [256];

   logic [18:0]        freq_queue [$];
   logic signed [15:0] sample_queue [$];
   uwo_tb_pkg::csr_write_type csr_queue [$];

   int  errors = 0;
   bit  quiet = 0;
   bit  req_acc = 0;
   int  cycles = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;

   // quarter-wave table, same Q30 integer series as uwo_pkg::sine_table
   function automatic int rom_point(int i);
      longint unsigned x, x2, t;
      longint sum;
      x = (64'd1686629713 * i) >> 8;
      x2 = (x * x) >> 30;
      t = x;
      sum = x;
      for (int n = 1; n <= 7; n++) begin
         t = ((t * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n % 2) sum -= t; else sum += t;
      end
      if (sum < 0) sum = 0;
      return int'(((64'(sum) * 64'd16384) + (64'd1 << 29)) >> 30);
   endfunction

   function automatic int half_sine(logic [31:0] lp);
      int v;
      logic [7:0] a;
      a = lp[29:22];
      if (lp[30]) v = (a == 0) ? 16384 : quarter_sine[8'(256 - a)];
      else v = quarter_sine[a];
      return lp[31] ? -v : v;
   endfunction

   function automatic int wave_point(logic [31:0] lp);
      int u, v;
      u = int'(lp[31:16]);
      case (p_wave)
         uwo_pkg::WAVE_SINE: return half_sine(lp);
         uwo_pkg::WAVE_SQUARE: return (2 * half_sine(lp) > int'(p_duty)) ? 32767 : -32768;
         uwo_pkg::WAVE_TRI: begin
            if (u < 16384) v = 2 * u;
            else if (u < 49152) v = 65536 - 2 * u;
            else v = 2 * u - 131072;
            return v > 32767 ? 32767 : v;
         end
         default: return u >= 32768 ? u - 65536 : u;
      endcase
   endfunction

   // one sample tick of the oscillator
   function automatic logic signed [15:0] next_sample(logic [18:0] f);
      int count, sum;
      longint feff;
      longint unsigned mag;
      logic [31:0] inc;
      logic [9:0]  k;
      if (p_wave == uwo_pkg::WAVE_NOISE) begin
         p_lfsr = p_lfsr[0] ? ((p_lfsr >> 1) ^ uwo_pkg::LFSR_TAPS) : (p_lfsr >> 1);
         return p_lfsr;
      end
      if (p_wave > uwo_pkg::WAVE_NOISE) return 0;
      count = (p_voices == 0) ? 1 : p_voices;
      sum = 0;
      for (int i = 0; i < count; i++) begin
         feff = f;
         if (i != 0) feff = (i % 2) ? feff - p_detune : feff + p_detune;
         mag = feff < 0 ? -feff : feff;
         inc = 32'((mag * p_pphz) / 1024);
         p_phase[i] = p_phase[i] + (feff < 0 ? -inc : inc);
         k = p_phase[i][31:22] + p_offset;
         sum += wave_point({k, 22'd0});
      end
      return 16'(sum / count);
   endfunction

   function automatic void apply_reg(uwo_tb_pkg::csr_write_type w);
      case (w.index)
         uwo_pkg::REG_WAVEFORM: p_wave   = w.data[2:0];
         uwo_pkg::REG_OFFSET:   p_offset = w.data[9:0];
         uwo_pkg::REG_DUTY:     p_duty   = w.data[15:0];
         uwo_pkg::REG_VOICES:   p_voices = w.data[3:0];
         uwo_pkg::REG_DETUNE:   p_detune = w.data[19:0];
         uwo_pkg::REG_PPHZ:     p_pphz   = w.data;
         default: ;
      endcase
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // request driver: hold a transaction until the monitor saw it accepted
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 0;
      end else if (req.valid && !req_acc) begin
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req.valid <= 0;
      end else if (freq_queue.size() > 0) begin
         req.valid <= 1;
         req.frequency <= freq_queue[0];
         if (!quiet && $urandom_range(0, 7) == 0) req_gap <= $urandom_range(1, 17);
      end else begin
         req.valid <= 0;
      end
   end

   // config driver
   always @(negedge clock) begin
      if (reset || (csr.valid && csr.ready) || csr_queue.size() == 0) begin
         csr.valid <= 0;
      end else if (!csr.valid) begin
         csr.valid <= 1;
         csr.index <= csr_queue[0].index;
         csr.data <= csr_queue[0].data;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) rsp.ready <= 0;
      else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp.ready <= 0;
      end else begin
         rsp.ready <= 1;
         if (!quiet && $urandom_range(0, 7) == 0) rsp_gap <= $urandom_range(1, 17);
      end
   end

   // monitor: predict on accepted ticks, check accepted samples
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_acc <= !reset && req.valid && req.ready;
      if (!reset) begin
         if (csr.valid && csr.ready) begin
            apply_reg(csr_queue[0]);
            void'(csr_queue.pop_front());
         end
         if (req.valid && req.ready) begin
            sample_queue.push_back(next_sample(req.frequency));
            void'(freq_queue.pop_front());
         end
         if (rsp.valid && rsp.ready) begin
            if (sample_queue.size() == 0) begin
               errors++;
               $display("%0t: sample expected none actual %0d", $time, rsp.sample);
            end else begin
               if (rsp.sample !== sample_queue[0]) begin
                  errors++;
                  $display("%0t: sample expected %0d actual %0d", $time,
                     sample_queue[0], rsp.sample);
               end
               void'(sample_queue.pop_front());
            end
         end
      end
      if (cycles > 2000000) begin
         $display("unison_wavetable_oscillator test failed");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] d);
      uwo_tb_pkg::csr_write_type w;
      w.index = idx;
      w.data = d;
      csr_queue.push_back(w);
      wait (csr_queue.size() == 0);
      @(posedge clock);
   endtask

   task automatic drain();
      wait (freq_queue.size() == 0 && sample_queue.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_setting(bit extreme);
      write_reg(uwo_pkg::REG_WAVEFORM, $urandom_range(0, 7) < 6 ? $urandom_range(0, 4)
                                                             : $urandom_range(0, 7));
      write_reg(uwo_pkg::REG_OFFSET, extreme ? 10'h3FF : $urandom_range(0, 1023));
      write_reg(uwo_pkg::REG_DUTY, $urandom());
      write_reg(uwo_pkg::REG_VOICES, extreme ? 15 : $urandom_range(0, 15));
      write_reg(uwo_pkg::REG_DETUNE, extreme ? 20'hFFFFF : $urandom() & 20'hFFFFF);
      write_reg(uwo_pkg::REG_PPHZ, extreme ? 32'hFFFFFFFF : $urandom());
   endtask

   // stimulus
   initial begin
      req.valid = 0;
      req.frequency = 0;
      rsp.ready = 0;
      csr.valid = 0;
      csr.index = 0;
      csr.data = 0;
      reset = 1;
      p_wave = uwo_pkg::WAVE_SINE; p_offset = 0; p_duty = 0; p_voices = 1;
      p_detune = 0; p_pphz = 0; p_lfsr = uwo_pkg::LFSR_SEED;
      foreach (p_phase[i]) p_phase[i] = 0;
      for (int i = 0; i < 256; i++) quarter_sine[i] = rom_point(i);
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: each waveform, extreme frequencies, big detune going negative
      write_reg(uwo_pkg::REG_PPHZ, 32'h4000_0000);
      write_reg(uwo_pkg::REG_VOICES, 15);
      write_reg(uwo_pkg::REG_DETUNE, 20'd300000);
      write_reg(uwo_pkg::REG_DUTY, 32'h0000_8000);
      for (int w = 0; w < 8; w++) begin
         write_reg(uwo_pkg::REG_WAVEFORM, w);
         freq_queue.push_back(19'd0);
         freq_queue.push_back(19'h7FFFF);
         freq_queue.push_back(19'd12345);
         drain();
      end
      write_reg(uwo_pkg::REG_VOICES, 0);
      write_reg(uwo_pkg::REG_WAVEFORM, uwo_pkg::WAVE_SQUARE);
      write_reg(uwo_pkg::REG_DUTY, 32'h7FFF);
      freq_queue.push_back(19'h55555);
      drain();

      // random phases under varied settings
      for (int ph = 0; ph < 14; ph++) begin
         random_setting(ph == 3);
         if (ph == 12) quiet = 1;
         for (int n = 0; n < 50; n++)
            freq_queue.push_back($urandom_range(0, 3) == 0 ? 19'($urandom())
                                 : 19'($urandom_range(0, 20000)));
         drain();
      end

      if (errors == 0 && csr_queue.size() == 0)
         $display("unison_wavetable_oscillator test passed");
      else
         $display("unison_wavetable_oscillator test failed");
      $finish;
   end
endmodule
